/* sv/qrp_pkg.sv */
// shared types and constants for the queue with reverse-prefix block
`timescale 1ns / 1ps

package qrp_pkg;

    // fixed field widths
    localparam int ACTION_W   = 2;
    localparam int VALUE_W    = 32;
    localparam int KCOUNT_W   = 6;
    localparam int STATUS_W   = 2;
    localparam int IN_TDATA_W = 40;
    localparam int OUT_TDATA_W = 32;

    // requested action, carried on the input tuser
    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQ  = 2'd0,
        ACT_DEQ  = 2'd1,
        ACT_LIST = 2'd2,
        ACT_REV  = 2'd3
    } t_action;

    // result status, carried on the output tuser
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DEQ,
        S_LIST,
        S_SWAP_RB,
        S_SWAP_WA,
        S_SWAP_WB,
        S_DONE
    } t_state;

endpackage

/* sv/qrp_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module qrp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

/* sv/queue_with_reverse_prefix_core.sv */
// Bounded word queue in a ring ram with enqueue, dequeue, list and reverse-first-k.
// Enqueue, rejected actions, reverse of k < 2: result from S_DECODE; dequeue from S_DEQ.
// List: results from S_LIST, one per cycle while not stalled, occupancy results in all.
// Reverse of k >= 2: floor(k/2) swaps through S_SWAP_WA and S_SWAP_WB, then S_DONE.
// One item is in work at a time; the next is taken once the sequencer is back to idle.
// Reset (i_rst_n low, synchronous) empties the queue; the ram contents are not cleared.
`timescale 1ns / 1ps

module queue_with_reverse_prefix_core
    import qrp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // value[31:0], reverse_count[37:32], zero pad
    input  logic [ACTION_W-1:0]    i_s_tuser,   // action[1:0]
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // data_out[31:0]
    output logic [STATUS_W-1:0]    o_m_tuser,   // status[1:0]
    output logic                   o_m_tlast
);

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CW > KCOUNT_W) ? CW + 1 : KCOUNT_W + 1;

    // ring slot of a queue position
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = (CW + 1)'(head) + (CW + 1)'(pos);
        if (sum >= (CW + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (CW + 1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    t_state                r_state, n_state;
    t_action               r_action;
    logic [VALUE_W-1:0]    r_value;
    logic [KCOUNT_W-1:0]   r_k;
    logic [AW-1:0]         r_head;
    logic [CW-1:0]         r_occ;
    logic [CW-1:0]         r_pos;
    logic [CW-1:0]         r_lo;
    logic [CW-1:0]         r_hi;
    logic [VALUE_W-1:0]    r_tmp;
    logic                  r_more;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [VALUE_W-1:0]    r_out_data;
    logic                  r_out_last;

    logic                  out_free;
    logic                  in_xfer;
    logic                  is_full;
    logic                  is_empty;
    logic                  k_over;
    logic                  k_small;
    logic                  list_last;
    logic                  wa_more;

    logic                  emit;
    t_status               emit_status;
    logic [VALUE_W-1:0]    emit_data;
    logic                  emit_last;
    logic                  rd_en;
    logic [CW-1:0]         rd_pos;
    logic                  wr_en;
    logic [CW-1:0]         wr_pos;
    logic [VALUE_W-1:0]    wr_data;
    logic [VALUE_W-1:0]    rd_data;

    // handshake and status terms
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign is_full    = (r_occ == CW'(QUEUE_DEPTH));
    assign is_empty   = (r_occ == '0);
    assign k_over     = CMP_W'(r_k) > CMP_W'(r_occ);
    assign k_small    = (r_k < KCOUNT_W'(2));
    assign list_last  = ((CW + 1)'(r_pos) + (CW + 1)'(1)) == (CW + 1)'(r_occ);
    assign wa_more    = ((CW + 1)'(r_lo) + (CW + 1)'(2)) < (CW + 1)'(r_hi);

    // ring storage
    qrp_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(slot_of(r_head, wr_pos)),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(slot_of(r_head, rd_pos)),
        .o_rd_data(rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (r_action)
                    ACT_ENQ: begin
                        if (out_free) n_state = S_IDLE;
                    end
                    ACT_DEQ: begin
                        if (!is_empty)     n_state = S_DEQ;
                        else if (out_free) n_state = S_IDLE;
                    end
                    ACT_LIST: begin
                        if (!is_empty)     n_state = S_LIST;
                        else if (out_free) n_state = S_IDLE;
                    end
                    ACT_REV: begin
                        if (!k_over && !k_small) n_state = S_SWAP_RB;
                        else if (out_free)       n_state = S_IDLE;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DEQ: begin
                if (out_free) n_state = S_IDLE;
            end
            S_LIST: begin
                if (out_free && list_last) n_state = S_IDLE;
            end
            S_SWAP_RB: n_state = S_SWAP_WA;
            S_SWAP_WA: n_state = S_SWAP_WB;
            S_SWAP_WB: n_state = r_more ? S_SWAP_WA : S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: result emission and ram access
    always_comb begin
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_data   = '0;
        emit_last   = 1'b1;
        rd_en       = 1'b0;
        rd_pos      = '0;
        wr_en       = 1'b0;
        wr_pos      = '0;
        wr_data     = r_value;
        unique case (r_state)
            S_IDLE: ;
            S_DECODE: begin
                unique case (r_action)
                    ACT_ENQ: begin
                        emit        = out_free;
                        emit_status = is_full ? ST_FULL : ST_OK;
                        wr_en       = out_free && !is_full;
                        wr_pos      = r_occ;
                    end
                    ACT_DEQ, ACT_LIST: begin
                        if (is_empty) begin
                            emit        = out_free;
                            emit_status = ST_EMPTY;
                        end else begin
                            rd_en = 1'b1;
                        end
                    end
                    ACT_REV: begin
                        if (k_over) begin
                            emit        = out_free;
                            emit_status = ST_RANGE;
                        end else if (k_small) begin
                            emit = out_free;
                        end else begin
                            rd_en = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_DEQ: begin
                emit      = out_free;
                emit_data = rd_data;
            end
            S_LIST: begin
                emit      = out_free;
                emit_data = rd_data;
                emit_last = list_last;
                rd_en     = out_free && !list_last;
                rd_pos    = r_pos + CW'(1);
            end
            S_SWAP_RB: begin
                rd_en  = 1'b1;
                rd_pos = r_hi;
            end
            S_SWAP_WA: begin
                wr_en   = 1'b1;
                wr_pos  = r_lo;
                wr_data = rd_data;
                rd_en   = wa_more;
                rd_pos  = r_lo + CW'(1);
            end
            S_SWAP_WB: begin
                wr_en   = 1'b1;
                wr_pos  = r_hi;
                wr_data = r_tmp;
                rd_en   = r_more;
                rd_pos  = r_hi - CW'(1);
            end
            S_DONE: begin
                emit = out_free;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DECODE && r_action == ACT_ENQ && out_free && !is_full) begin
                r_occ <= r_occ + CW'(1);
            end
            if (r_state == S_DEQ && out_free) begin
                r_occ  <= r_occ - CW'(1);
                r_head <= (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);
            end
        end
    end

    // item latch and work registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_action <= t_action'(i_s_tuser);
            r_value  <= i_s_tdata[VALUE_W-1:0];
            r_k      <= i_s_tdata[VALUE_W +: KCOUNT_W];
        end
        if (r_state == S_DECODE) begin
            r_pos <= '0;
            r_lo  <= '0;
            r_hi  <= CW'(CMP_W'(r_k) - CMP_W'(1));
        end
        if (r_state == S_LIST && out_free && !list_last) begin
            r_pos <= r_pos + CW'(1);
        end
        if (r_state == S_SWAP_RB) begin
            r_tmp <= rd_data;
        end
        if (r_state == S_SWAP_WA) begin
            r_lo   <= r_lo + CW'(1);
            r_more <= wa_more;
        end
        if (r_state == S_SWAP_WB) begin
            r_hi <= r_hi - CW'(1);
            if (r_more) r_tmp <= rd_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_status <= emit_status;
            r_out_data   <= emit_data;
            r_out_last   <= emit_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

`ifndef SYNTH
    // occupancy never passes the ring size
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    // swap pointers stay ordered while swapping
    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWAP_WA) |-> (r_lo < r_hi))
        else $error("swap pointers crossed");

    // listing, dequeue and idle never write the ram
    a_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST || r_state == S_DEQ || r_state == S_IDLE) |-> !wr_en)
        else $error("unexpected ram write");

    // an accepted item is decoded on the next cycle
    a_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_DECODE))
        else $error("accepted item not decoded");

    // a result is never overwritten while stalled
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("result overrun");
`endif

endmodule
